// ===== sv/stwc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package stwc_pkg;

  // Default and fixed widths.
  localparam int unsigned CountWidthDef = 32;
  localparam int unsigned ResultWidth   = 32;
  localparam int unsigned NumCounts     = 6;

  // Positions of the counters in the bank.
  localparam int unsigned IdxBytes   = 0;
  localparam int unsigned IdxWords   = 1;
  localparam int unsigned IdxLines   = 2;
  localparam int unsigned IdxCode    = 3;
  localparam int unsigned IdxComment = 4;
  localparam int unsigned IdxBlank   = 5;

  // Configuration register indexes.
  localparam logic [1:0] RegWordEnable     = 2'd0;
  localparam logic [1:0] RegLineEnable     = 2'd1;
  localparam logic [1:0] RegClassifyEnable = 2'd2;

  // Byte codes.
  localparam logic [7:0] ChSlash   = 8'h2F;
  localparam logic [7:0] ChStar    = 8'h2A;
  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChTab     = 8'h09;
  localparam logic [7:0] ChCr      = 8'h0D;

  // Saturation value of the code byte run.
  localparam logic [1:0] RunMax = 2'd3;

  // Configuration bits seen by the counter core.
  typedef struct packed {
    logic word_en;
    logic line_en;
    logic cls_en;
  } cfg_t;

  // One result word: all six totals.
  typedef logic [NumCounts-1:0][ResultWidth-1:0] result_t;

  // Whitespace: space, tab, newline, vertical tab, form feed, carriage return.
  function automatic logic is_ws(input logic [7:0] b);
    return (b == ChSpace) || ((b >= ChTab) && (b <= ChCr));
  endfunction

endpackage

`default_nettype wire

// ===== sv/stwc_in_reg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module stwc_in_reg (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] text_byte_i,
  input  wire logic       end_of_text_i,
  input  wire logic       advance_i,
  output logic            valid_o,
  output logic [7:0]      byte_o,
  output logic            last_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       last_q;
  logic       accept;

  // The register is free when empty or when its word moves on this cycle.
  assign in_stall_o = valid_q && !advance_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= text_byte_i;
      last_q <= end_of_text_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;
  assign last_o  = last_q;

endmodule

`default_nettype wire

// ===== sv/stwc_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

module stwc_core #(
  parameter int unsigned COUNT_WIDTH = stwc_pkg::CountWidthDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire stwc_pkg::cfg_t       cfg_i,
  input  wire logic                 advance_i,
  input  wire logic [7:0]           byte_i,
  input  wire logic                 last_i,
  output stwc_pkg::result_t         result_o
);

  typedef logic [stwc_pkg::NumCounts-1:0][COUNT_WIDTH-1:0] bank_t;

  logic       in_word_q, in_word_d;
  logic       pslash_q, pslash_d;
  logic       popen_q, popen_d;
  logic       pstar_q, pstar_d;
  logic       in_blk_q, in_blk_d;
  logic       has_cmt_q, has_cmt_d;
  logic       blank_q, blank_d;
  logic [1:0] run_q, run_d;
  bank_t      cnt_q, cnt_d, cnt_upd;

  // Saturating increment of one counter.
  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
    return (&c) ? c : c + COUNT_WIDTH'(1);
  endfunction

  // Code byte run steps down when a comment opener gives back its first slash.
  function automatic logic [1:0] run_dec(input logic [1:0] r);
    return (r != 2'd0) ? r - 2'd1 : r;
  endfunction

  // Per-byte state update, in the order of the scan rules.
  always_comb begin
    logic opener;
    logic star;
    logic ws;
    logic nl;
    opener    = 1'b0;
    star      = 1'b0;
    ws        = stwc_pkg::is_ws(byte_i);
    nl        = (byte_i == stwc_pkg::ChNewline);
    in_word_d = in_word_q;
    pslash_d  = pslash_q;
    popen_d   = popen_q;
    pstar_d   = pstar_q;
    in_blk_d  = in_blk_q;
    has_cmt_d = has_cmt_q;
    blank_d   = blank_q;
    run_d     = run_q;
    cnt_upd   = cnt_q;

    cnt_upd[stwc_pkg::IdxBytes] = sat_inc(cnt_q[stwc_pkg::IdxBytes]);

    // Comment tracking.
    if (cfg_i.cls_en) begin
      if (byte_i == stwc_pkg::ChSlash) begin
        if (pslash_q && !has_cmt_q) begin
          has_cmt_d = 1'b1;
          run_d     = run_dec(run_q);
        end
        pslash_d = 1'b1;
        if (pstar_q && in_blk_q) begin
          in_blk_d = 1'b0;
        end else begin
          opener = 1'b1;
        end
      end else begin
        pslash_d = 1'b0;
      end
      if (byte_i == stwc_pkg::ChStar) begin
        if (popen_q && !in_blk_q) begin
          in_blk_d = 1'b1;
          if (!has_cmt_q) begin
            run_d = run_dec(run_q);
          end
          has_cmt_d = 1'b1;
        end else begin
          star = 1'b1;
        end
      end
      popen_d = opener;
      pstar_d = star;
    end

    // Word, line and line class counting.
    if (ws) begin
      if (cfg_i.word_en && in_word_q) begin
        cnt_upd[stwc_pkg::IdxWords] = sat_inc(cnt_q[stwc_pkg::IdxWords]);
        in_word_d = 1'b0;
      end
      if (nl) begin
        if (cfg_i.line_en) begin
          cnt_upd[stwc_pkg::IdxLines] = sat_inc(cnt_q[stwc_pkg::IdxLines]);
        end
        if (cfg_i.cls_en) begin
          if (run_d > 2'd1) begin
            cnt_upd[stwc_pkg::IdxCode] = sat_inc(cnt_q[stwc_pkg::IdxCode]);
          end else if (has_cmt_d && !blank_d) begin
            cnt_upd[stwc_pkg::IdxComment] = sat_inc(cnt_q[stwc_pkg::IdxComment]);
          end else begin
            cnt_upd[stwc_pkg::IdxBlank] = sat_inc(cnt_q[stwc_pkg::IdxBlank]);
          end
          run_d     = 2'd0;
          has_cmt_d = in_blk_d;
          blank_d   = 1'b1;
        end
      end
    end else begin
      if (cfg_i.cls_en) begin
        blank_d = 1'b0;
        if (!has_cmt_d && !in_blk_d && (run_d != stwc_pkg::RunMax)) begin
          run_d = run_d + 2'd1;
        end
      end
      if (cfg_i.word_en) begin
        in_word_d = 1'b1;
      end
    end

    cnt_d = cnt_upd;

    // The last byte of a text returns all per-text state to its reset value.
    if (last_i) begin
      in_word_d = 1'b0;
      pslash_d  = 1'b0;
      popen_d   = 1'b0;
      pstar_d   = 1'b0;
      in_blk_d  = 1'b0;
      has_cmt_d = 1'b0;
      blank_d   = 1'b1;
      run_d     = 2'd0;
      cnt_d     = '0;
    end
  end

  // Totals as reported: low result bits of each counter.
  always_comb begin
    for (int i = 0; i < stwc_pkg::NumCounts; i++) begin
      result_o[i] = stwc_pkg::ResultWidth'(cnt_upd[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_word_q <= 1'b0;
      pslash_q  <= 1'b0;
      popen_q   <= 1'b0;
      pstar_q   <= 1'b0;
      in_blk_q  <= 1'b0;
      has_cmt_q <= 1'b0;
      blank_q   <= 1'b1;
      run_q     <= 2'd0;
      cnt_q     <= '0;
    end else if (advance_i) begin
      in_word_q <= in_word_d;
      pslash_q  <= pslash_d;
      popen_q   <= popen_d;
      pstar_q   <= pstar_d;
      in_blk_q  <= in_blk_d;
      has_cmt_q <= has_cmt_d;
      blank_q   <= blank_d;
      run_q     <= run_d;
      cnt_q     <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/source_text_line_word_counter_unit.sv =====
// A result word is registered when the byte marked end of text leaves the input register.
// Throughput: one byte per cycle; the input register, the counter update and the
// result register form a two-stage pipeline that stalls its input only while a
// byte marked end of text waits behind a result that is still stalled.
// Reset: all counters and per-text flags clear but the blank flag, which sets; the word
// and line enables set, classification is off, and both pipeline registers empty.
`timescale 1ns / 1ps
`default_nettype none

module source_text_line_word_counter_unit #(
  parameter int unsigned COUNT_WIDTH = stwc_pkg::CountWidthDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration port
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic        cfg_wdata_i,
  // Input channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  text_byte_i,
  input  wire logic        end_of_text_i,
  // Output channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      byte_total_o,
  output logic [31:0]      word_total_o,
  output logic [31:0]      line_total_o,
  output logic [31:0]      code_lines_o,
  output logic [31:0]      comment_lines_o,
  output logic [31:0]      blank_lines_o
);

  stwc_pkg::cfg_t    cfg_q;
  stwc_pkg::result_t core_res;
  stwc_pkg::result_t res_q;
  logic              s1_valid;
  logic [7:0]        s1_byte;
  logic              s1_last;
  logic              advance;
  logic              out_valid_q, out_valid_d;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.word_en <= 1'b1;
      cfg_q.line_en <= 1'b1;
      cfg_q.cls_en  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        stwc_pkg::RegWordEnable:     cfg_q.word_en <= cfg_wdata_i;
        stwc_pkg::RegLineEnable:     cfg_q.line_en <= cfg_wdata_i;
        stwc_pkg::RegClassifyEnable: cfg_q.cls_en  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // A byte moves on unless it would produce a result while the last one still waits.
  assign advance = s1_valid && !(s1_last && out_valid_q && out_stall_i);

  stwc_in_reg u_in_reg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .text_byte_i   (text_byte_i),
    .end_of_text_i (end_of_text_i),
    .advance_i     (advance),
    .valid_o       (s1_valid),
    .byte_o        (s1_byte),
    .last_o        (s1_last)
  );

  stwc_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .advance_i (advance),
    .byte_i    (s1_byte),
    .last_i    (s1_last),
    .result_o  (core_res)
  );

  // Result register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (advance && s1_last) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s1_last) begin
      res_q <= core_res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign byte_total_o    = res_q[stwc_pkg::IdxBytes];
  assign word_total_o    = res_q[stwc_pkg::IdxWords];
  assign line_total_o    = res_q[stwc_pkg::IdxLines];
  assign code_lines_o    = res_q[stwc_pkg::IdxCode];
  assign comment_lines_o = res_q[stwc_pkg::IdxComment];
  assign blank_lines_o   = res_q[stwc_pkg::IdxBlank];

endmodule

`default_nettype wire
